@@ src/tct_pkg.sv @@
// Package for the timestamp correlation table: codes, defaults and hash constants.
// Used by the front end, the back end, the top level and the bench; depends on nothing.
package tct_pkg;

  localparam int TABLE_DEPTH_DEFAULT    = 1024;
  localparam int NAME_MAX_CHARS_DEFAULT = 32;

  localparam logic [31:0] HASH_MULT     = 32'd31;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  // Item kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_MATCH  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EXPIRED   = 3'd3;
  localparam logic [2:0] ST_TICK_DONE = 3'd4;

endpackage

@@ src/tct_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing; the package is not needed here.
interface tct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] app_id;
  logic [15:0] sample_count;
  logic [5:0]  name_length;
  logic [63:0] name_chars_0;
  logic [63:0] name_chars_1;
  logic [63:0] name_chars_2;
  logic [63:0] name_chars_3;
  logic [63:0] hw_timestamp;

  modport source (output valid, kind, app_id, sample_count, name_length, name_chars_0,
                  name_chars_1, name_chars_2, name_chars_3, hw_timestamp, input ready);
  modport sink   (input valid, kind, app_id, sample_count, name_length, name_chars_0,
                  name_chars_1, name_chars_2, name_chars_3, hw_timestamp, output ready);
endinterface

interface tct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] matched_timestamp;
  logic [31:0] failure_count;

  modport source (output valid, status, matched_timestamp, failure_count, input ready);
  modport sink   (input valid, status, matched_timestamp, failure_count, output ready);
endinterface

@@ src/tct_front.sv @@
// Front end: accepts items, folds the key hash one character per cycle and takes the
// slot from the low hash bits (TABLE_DEPTH is a power of two). Depends on tct_pkg, tct_in_if.
module tct_front #(
  parameter int TABLE_DEPTH    = tct_pkg::TABLE_DEPTH_DEFAULT,
  parameter int NAME_MAX_CHARS = tct_pkg::NAME_MAX_CHARS_DEFAULT,
  parameter int CMD_W          = 8
) (
  input  logic             clk,
  input  logic             rst,
  tct_in_if.sink           in_ch,
  input  logic             clearing,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [CMD_W-1:0] push_data
);
  import tct_pkg::*;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NAME_W = 8 * NAME_MAX_CHARS;
  localparam int IDX_W  = (NAME_MAX_CHARS > 1) ? $clog2(NAME_MAX_CHARS) : 1;
  localparam logic [5:0]      LEN_MAX = 6'(NAME_MAX_CHARS);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t            state;
  logic [1:0]         kind;
  logic [15:0]        app;
  logic [15:0]        smp;
  logic [5:0]         len;
  logic [NAME_W-1:0]  name;
  logic [63:0]        stamp;
  logic [31:0]        h;
  logic [5:0]         idx;

  logic [5:0]         len_eff;
  logic [255:0]       name_all;
  logic [NAME_W-1:0]  name_masked;
  logic [31:0]        hash_init;
  logic [31:0]        h_step;
  logic               take;

  assign len_eff  = (in_ch.name_length > LEN_MAX) ? LEN_MAX : in_ch.name_length;
  assign name_all = {in_ch.name_chars_3, in_ch.name_chars_2,
                     in_ch.name_chars_1, in_ch.name_chars_0};

  // Bytes at or beyond the effective length are zeroed, so stored names compare whole.
  always_comb begin
    for (int i = 0; i < NAME_MAX_CHARS; i++) begin
      name_masked[i*8 +: 8] = (6'(i) < len_eff) ? name_all[i*8 +: 8] : 8'd0;
    end
  end

  assign hash_init = 32'(in_ch.app_id) * HASH_MULT + 32'(in_ch.sample_count);
  assign h_step    = h * HASH_MULT + 32'(name[idx[IDX_W-1:0]*8 +: 8]);

  assign in_ch.ready = (state == F_IDLE) && !clearing;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = (state == F_PUSH);
  assign push_data   = {kind, h[SLOT_W-1:0], app, smp, len, name, stamp};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (take) begin
            kind  <= in_ch.kind;
            app   <= in_ch.app_id;
            smp   <= in_ch.sample_count;
            len   <= len_eff;
            name  <= name_masked;
            stamp <= in_ch.hw_timestamp;
            h     <= hash_init;
            idx   <= '0;
            if (in_ch.kind == KIND_TICK) begin
              state <= F_PUSH;
            end else if (in_ch.kind == KIND_IGNORE) begin
              state <= F_IDLE;
            end else if (len_eff == 6'd0) begin
              state <= F_PUSH;
            end else begin
              state <= F_HASH;
            end
          end
        end
        F_HASH: begin
          h   <= h_step;
          idx <= idx + 6'd1;
          if (idx + 6'd1 == len) begin
            idx   <= '0;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ src/tct_cmd_fifo.sv @@
// Small command queue between the hashing front end and the table back end.
// Depends on nothing outside this file.
module tct_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ src/tct_back.sv @@
// Back end: table memories, clearing pass, compare/expiry logic, second counter,
// failure counter and the result register. Depends on tct_pkg and tct_out_if.
module tct_back #(
  parameter int TABLE_DEPTH    = tct_pkg::TABLE_DEPTH_DEFAULT,
  parameter int NAME_MAX_CHARS = tct_pkg::NAME_MAX_CHARS_DEFAULT,
  parameter int CMD_W          = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             timeout_wr_en,
  input  logic [15:0]      timeout_wr_data,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [CMD_W-1:0] pop_data,
  output logic             clearing,
  tct_out_if.source        out_ch
);
  import tct_pkg::*;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NAME_W = 8 * NAME_MAX_CHARS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} bstate_t;

  bstate_t state;

  // Table storage.
  logic              m_valid [TABLE_DEPTH];
  logic [15:0]       m_app   [TABLE_DEPTH];
  logic [15:0]       m_smp   [TABLE_DEPTH];
  logic [5:0]        m_len   [TABLE_DEPTH];
  logic [NAME_W-1:0] m_name  [TABLE_DEPTH];
  logic [63:0]       m_stamp [TABLE_DEPTH];
  logic [31:0]       m_sec   [TABLE_DEPTH];

  // Registered read of the addressed slot.
  logic              r_valid;
  logic [15:0]       r_app;
  logic [15:0]       r_smp;
  logic [5:0]        r_len;
  logic [NAME_W-1:0] r_name;
  logic [63:0]       r_stamp;
  logic [31:0]       r_sec;

  // Unpacked head of the queue and the command held for execution.
  logic [1:0]        q_kind;
  logic [SLOT_W-1:0] q_slot;
  logic [15:0]       q_app;
  logic [15:0]       q_smp;
  logic [5:0]        q_len;
  logic [NAME_W-1:0] q_name;
  logic [63:0]       q_stamp;
  logic [1:0]        c_kind;
  logic [SLOT_W-1:0] c_slot;
  logic [15:0]       c_app;
  logic [15:0]       c_smp;
  logic [5:0]        c_len;
  logic [NAME_W-1:0] c_name;
  logic [63:0]       c_stamp;

  logic [SLOT_W-1:0] clr_addr;
  logic [31:0]       cur_sec;
  logic [31:0]       fail_total;
  logic [15:0]       timeout;

  logic              out_valid;
  logic [2:0]        out_status;
  logic [63:0]       out_stamp;
  logic [31:0]       out_fail;

  logic              pop;
  logic              exec_go;
  logic              same;
  logic              expired;
  logic [31:0]       age;
  logic              fail_inc;
  logic [31:0]       fail_next;
  logic [2:0]        status_next;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic              wvalid;

  assign {q_kind, q_slot, q_app, q_smp, q_len, q_name, q_stamp} = pop_data;

  assign clearing  = (state == S_CLEAR);
  assign pop_ready = (state == S_IDLE);
  assign pop       = pop_valid && pop_ready;
  assign exec_go   = (state == S_EXEC) && (!out_valid || out_ch.ready);

  assign same = r_valid && (r_app == c_app) && (r_smp == c_smp) &&
                (r_len == c_len) && (r_name == c_name);
  assign age     = cur_sec - r_sec;
  assign expired = age > {16'd0, timeout};

  always_comb begin
    status_next = ST_INSERTED;
    fail_inc    = 1'b0;
    case (c_kind)
      KIND_TICK:   status_next = ST_TICK_DONE;
      KIND_MATCH: begin
        if (!same) begin
          status_next = ST_NOT_FOUND;
          fail_inc    = 1'b1;
        end else if (expired) begin
          status_next = ST_EXPIRED;
          fail_inc    = 1'b1;
        end else begin
          status_next = ST_MATCHED;
        end
      end
      default:     status_next = ST_INSERTED;
    endcase
  end

  assign fail_next = (fail_inc && (fail_total != '1)) ? fail_total + 32'd1 : fail_total;

  // One write port: the clearing pass, an insert, or the clear of a matched/expired slot.
  always_comb begin
    we     = 1'b0;
    waddr  = c_slot;
    wvalid = 1'b0;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (exec_go && (c_kind == KIND_INSERT)) begin
      we     = 1'b1;
      wvalid = 1'b1;
    end else if (exec_go && (c_kind == KIND_MATCH) && same) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      m_valid[waddr] <= wvalid;
      m_app[waddr]   <= c_app;
      m_smp[waddr]   <= c_smp;
      m_len[waddr]   <= c_len;
      m_name[waddr]  <= c_name;
      m_stamp[waddr] <= c_stamp;
      m_sec[waddr]   <= cur_sec;
    end
    if (pop) begin
      r_valid <= m_valid[q_slot];
      r_app   <= m_app[q_slot];
      r_smp   <= m_smp[q_slot];
      r_len   <= m_len[q_slot];
      r_name  <= m_name[q_slot];
      r_stamp <= m_stamp[q_slot];
      r_sec   <= m_sec[q_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      cur_sec    <= '0;
      fail_total <= '0;
      timeout    <= TIMEOUT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (timeout_wr_en) begin
        timeout <= timeout_wr_data;
      end
      // A new result replaces the one taken in the same cycle.
      if (out_valid && out_ch.ready && !exec_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            c_kind  <= q_kind;
            c_slot  <= q_slot;
            c_app   <= q_app;
            c_smp   <= q_smp;
            c_len   <= q_len;
            c_name  <= q_name;
            c_stamp <= q_stamp;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            out_valid  <= 1'b1;
            out_status <= status_next;
            out_stamp  <= (status_next == ST_MATCHED) ? r_stamp : 64'd0;
            out_fail   <= fail_next;
            fail_total <= fail_next;
            if (c_kind == KIND_TICK) begin
              cur_sec <= cur_sec + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.status            = out_status;
  assign out_ch.matched_timestamp = out_stamp;
  assign out_ch.failure_count     = out_fail;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("command taken during clearing pass");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fail_total >= $past(fail_total)))
    else $error("failure count went down");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (exec_go && (c_kind == KIND_TICK)) |=> (cur_sec == $past(cur_sec) + 32'd1))
    else $error("tick did not advance the second counter");

endmodule

@@ src/timestamp_correlation_table.sv @@
// Timestamp correlation table, top level: front end, command queue and table back end.
// Depends on tct_pkg, tct_if, tct_front, tct_cmd_fifo and tct_back.
//
// Usage: input beats arrive on in_ch (valid/ready). An insert beat stores its hardware
// timestamp under the key (app id, stream name, sample count); a match beat looks the
// key up, returns the stored timestamp and frees the slot; a tick beat advances the
// seconds counter. Kind 3 beats are taken and dropped without a result. Every other
// beat yields exactly one result beat on out_ch with a status, the matched timestamp
// (zero unless matched) and the saturating failure count.
// The front end accepts a beat, folds the hash over each effective name character in turn
// and then hands the command over, waiting while the queue is full; it takes no new beat
// until the command is handed over.
// The slot is the low bits of the hash, so TABLE_DEPTH must be a power of two.
// The back end reads the addressed slot into a register, then compares and writes, so for
// non-empty names the hash loop sets the rate while results are taken; a beat passes the
// front-end registers, the command queue, the slot read register and the result register.
// A two-entry queue separates front and back, and the result register lets the next
// command be read while a result waits, so a stalled receiver only blocks once the
// queue fills. After reset the back end clears the valid bit of every slot, one slot
// per cycle; no input beat is taken meanwhile. The timeout register (reset 5) is written
// at an edge where timeout_wr_en is high; the user must write it only while no beat is
// in flight, as the block itself does not enforce this.
module timestamp_correlation_table #(
  parameter int TABLE_DEPTH    = tct_pkg::TABLE_DEPTH_DEFAULT,
  parameter int NAME_MAX_CHARS = tct_pkg::NAME_MAX_CHARS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tct_in_if.sink      in_ch,
  tct_out_if.source   out_ch,
  input  logic        timeout_wr_en,
  input  logic [15:0] timeout_wr_data
);
  import tct_pkg::*;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Command: kind, slot, app id, sample count, length, masked name, timestamp.
  localparam int CMD_W  = 2 + SLOT_W + 16 + 16 + 6 + 8 * NAME_MAX_CHARS + 64;

  logic             push_valid;
  logic             push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [CMD_W-1:0] pop_data;
  logic             clearing;

  tct_front #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .NAME_MAX_CHARS(NAME_MAX_CHARS),
    .CMD_W         (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .clearing  (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  tct_cmd_fifo #(
    .WIDTH(CMD_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  tct_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .NAME_MAX_CHARS(NAME_MAX_CHARS),
    .CMD_W         (CMD_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .timeout_wr_en  (timeout_wr_en),
    .timeout_wr_data(timeout_wr_data),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .clearing       (clearing),
    .out_ch         (out_ch)
  );

endmodule

@@ bench/timestamp_correlation_table_tb.sv @@
// Self-checking bench for the timestamp correlation table: directed table, then random beats.
// Depends on tct_pkg, tct_if and the timestamp_correlation_table RTL.
module timestamp_correlation_table_tb;
  import tct_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] app;
    logic [15:0] smp;
    logic [5:0]  len;
    logic [255:0] name;
    logic [63:0] stamp;
  } record_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] stamp;
    logic [31:0] fails;
  } outcome_t;

  // One row of the directed table. When check_typed is set, typed_status must match.
  typedef struct {
    record_t rec;
    bit      check_typed;
    logic [2:0] typed_status;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic timeout_wr_en = 1'b0;
  logic [15:0] timeout_wr_data = 16'd0;

  tct_in_if  in_ch();
  tct_out_if out_ch();

  timestamp_correlation_table dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .timeout_wr_en(timeout_wr_en), .timeout_wr_data(timeout_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the table, kept at the block's widths.
  logic         slot_used [DEPTH];
  logic [15:0]  slot_app [DEPTH];
  logic [15:0]  slot_smp [DEPTH];
  logic [5:0]   slot_len [DEPTH];
  logic [255:0] slot_name [DEPTH];
  logic [63:0]  slot_stamp [DEPTH];
  logic [31:0]  slot_second [DEPTH];
  logic [31:0]  seconds_now;
  logic [31:0]  fail_total;
  logic [15:0]  timeout_now;

  outcome_t pending_results[$];
  logic [2:0] typed_status_q[$];
  bit         typed_check_q[$];
  int errors = 0;
  int idle_pct = 20;
  bit hold_sender = 1'b0;

  // Keys recently inserted, so that matches mostly hit.
  record_t recent_keys[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  function automatic logic [5:0] eff_len(input logic [5:0] len);
    return (len > 6'd32) ? 6'd32 : len;
  endfunction

  function automatic logic [255:0] masked_name(input logic [255:0] name, input logic [5:0] len);
    logic [255:0] m;
    m = '0;
    for (int i = 0; i < 32; i++) if (i < len) m[8*i +: 8] = 8'hFF;
    return name & m;
  endfunction

  function automatic logic [31:0] key_hash(input record_t r);
    logic [31:0] h;
    logic [5:0] n;
    n = eff_len(r.len);
    h = 32'(r.app) * HASH_MULT + 32'(r.smp);
    for (int i = 0; i < 32; i++) if (i < n) h = h * HASH_MULT + 32'(r.name[8*i +: 8]);
    return h;
  endfunction

  function automatic void bump_failures();
    if (fail_total != 32'hFFFF_FFFF) fail_total++;
  endfunction

  // Applies one accepted beat to the shadow and returns the result it must produce.
  function automatic bit correlate(input record_t r, output outcome_t o);
    int slot;
    logic [5:0] n;
    logic [255:0] nm;
    bit same;
    o = '0;
    if (r.kind == KIND_IGNORE) return 1'b0;
    if (r.kind == KIND_TICK) begin
      seconds_now++;
      o.status = ST_TICK_DONE;
      o.fails = fail_total;
      return 1'b1;
    end
    n = eff_len(r.len);
    nm = masked_name(r.name, n);
    slot = key_hash(r) % DEPTH;
    if (r.kind == KIND_INSERT) begin
      slot_used[slot] = 1'b1;
      slot_app[slot] = r.app;
      slot_smp[slot] = r.smp;
      slot_len[slot] = n;
      slot_name[slot] = nm;
      slot_stamp[slot] = r.stamp;
      slot_second[slot] = seconds_now;
      o.status = ST_INSERTED;
    end else begin
      same = slot_used[slot] && slot_app[slot] == r.app && slot_smp[slot] == r.smp &&
             slot_len[slot] == n && slot_name[slot] == nm;
      if (!same) begin
        bump_failures();
        o.status = ST_NOT_FOUND;
      end else if (seconds_now - slot_second[slot] > 32'(timeout_now)) begin
        slot_used[slot] = 1'b0;
        bump_failures();
        o.status = ST_EXPIRED;
      end else begin
        o.stamp = slot_stamp[slot];
        slot_used[slot] = 1'b0;
        o.status = ST_MATCHED;
      end
    end
    o.fails = fail_total;
    return 1'b1;
  endfunction

  // Sender side: hold the beat until accepted, with random idle cycles before it.
  // Valid stays high after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_beat(input record_t r, input bit check_typed, input logic [2:0] typed);
    outcome_t o;
    while (hold_sender || ($urandom_range(99) < idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= r.kind;
    in_ch.app_id <= r.app;
    in_ch.sample_count <= r.smp;
    in_ch.name_length <= r.len;
    {in_ch.name_chars_3, in_ch.name_chars_2, in_ch.name_chars_1, in_ch.name_chars_0} <= r.name;
    in_ch.hw_timestamp <= r.stamp;
    do @(posedge clk); while (!in_ch.ready);
    if (correlate(r, o)) begin
      pending_results.push_back(o);
      typed_check_q.push_back(check_typed);
      typed_status_q.push_back(typed);
    end
    if (r.kind == KIND_INSERT) begin
      recent_keys.push_back(r);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end
  endtask

  // Receiver side: random stalls on ready, and a check of each accepted result beat.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(out_ch.status), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (typed_check_q.pop_front() && out_ch.status !== typed_status_q[0])
            report_mismatch("typed status", 64'(out_ch.status), 64'(typed_status_q[0]));
          void'(typed_status_q.pop_front());
          if (out_ch.status !== want.status)
            report_mismatch("status", 64'(out_ch.status), 64'(want.status));
          if (out_ch.matched_timestamp !== want.stamp)
            report_mismatch("matched_timestamp", out_ch.matched_timestamp, want.stamp);
          if (out_ch.failure_count !== want.fails)
            report_mismatch("failure_count", 64'(out_ch.failure_count), 64'(want.fails));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: cycles without any accepted beat on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    timeout_wr_en <= 1'b1;
    timeout_wr_data <= value;
    @(posedge clk);
    timeout_wr_en <= 1'b0;
    timeout_now = value;
  endtask

  function automatic record_t make_rec(input logic [1:0] kind, input logic [15:0] app,
                                       input logic [15:0] smp, input logic [5:0] len,
                                       input logic [255:0] name, input logic [63:0] stamp);
    record_t r;
    r.kind = kind; r.app = app; r.smp = smp; r.len = len; r.name = name; r.stamp = stamp;
    return r;
  endfunction

  function automatic logic [255:0] rand_name();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // Random beat: mostly inserts and matches against recent keys, some ticks and noise.
  function automatic record_t random_rec();
    record_t r;
    int pick;
    pick = $urandom_range(99);
    r = make_rec(KIND_INSERT, 16'($urandom), 16'($urandom),
                 ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(6)),
                 rand_name(), rand_stamp());
    if (pick < 35) begin
      r.kind = KIND_INSERT;
    end else if (pick < 75 && recent_keys.size() != 0) begin
      r = recent_keys[$urandom_range(recent_keys.size() - 1)];
      r.kind = KIND_MATCH;
      r.stamp = rand_stamp();
      // Bytes beyond the length must not matter; sometimes a key is slightly altered.
      if ($urandom_range(3) == 0) r.name = r.name ^ (rand_name() & ~masked_name('1, eff_len(r.len)));
      if ($urandom_range(9) == 0) r.smp = r.smp + 16'd1;
    end else if (pick < 80) begin
      r.kind = KIND_MATCH;
    end else if (pick < 95) begin
      r.kind = KIND_TICK;
    end else begin
      r.kind = KIND_IGNORE;
    end
    return r;
  endfunction

  row_t directed[$];
  record_t key_a, key_b;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_IGNORE;
    in_ch.app_id = '0;
    in_ch.sample_count = '0;
    in_ch.name_length = '0;
    in_ch.name_chars_0 = '0;
    in_ch.name_chars_1 = '0;
    in_ch.name_chars_2 = '0;
    in_ch.name_chars_3 = '0;
    in_ch.hw_timestamp = '0;
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    seconds_now = '0;
    fail_total = '0;
    timeout_now = TIMEOUT_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Keys at the field extremes; all-ones name with a zero byte in it.
    key_a = make_rec(KIND_INSERT, 16'hFFFF, 16'hFFFF, 6'd32, {32{8'hFF}} & ~256'hFF00,
                     64'hFFFF_FFFF_FFFF_FFFF);
    key_b = make_rec(KIND_INSERT, 16'h0000, 16'h0000, 6'd0, '0, 64'd1);
    directed.push_back('{make_rec(KIND_MATCH, 16'd7, 16'd7, 6'd3, 256'h616263, '0),
                         1'b1, ST_NOT_FOUND});
    directed.push_back('{make_rec(KIND_TICK, '0, '0, '0, '0, '0), 1'b1, ST_TICK_DONE});
    directed.push_back('{make_rec(KIND_IGNORE, 16'hFFFF, 16'hFFFF, 6'h3F, '1, '1),
                         1'b0, 3'd0});
    directed.push_back('{key_a, 1'b1, ST_INSERTED});
    directed.push_back('{key_b, 1'b1, ST_INSERTED});
    // A longer length than the maximum must fold to the same key as 32 characters.
    key_a.kind = KIND_MATCH; key_a.len = 6'h3F;
    directed.push_back('{key_a, 1'b1, ST_MATCHED});
    directed.push_back('{key_a, 1'b1, ST_NOT_FOUND});
    key_b.kind = KIND_MATCH;
    directed.push_back('{key_b, 1'b0, 3'd0});
    // Garbage beyond the length is ignored by the hash and the compare.
    directed.push_back('{make_rec(KIND_INSERT, 16'd5, 16'd9, 6'd2, 256'h1234, 64'hABCD),
                         1'b1, ST_INSERTED});
    for (int i = 0; i < 6; i++)
      directed.push_back('{make_rec(KIND_TICK, '0, '0, '0, '0, '0), 1'b1, ST_TICK_DONE});
    directed.push_back('{make_rec(KIND_MATCH, 16'd5, 16'd9, 6'd2, {240'hFFFF, 16'h1234}, '0),
                         1'b1, ST_EXPIRED});
    directed.push_back('{make_rec(KIND_INSERT, 16'h8000, 16'h0001, 6'd32, rand_name(),
                                  64'h8000_0000_0000_0000), 1'b0, 3'd0});
    foreach (directed[i]) send_beat(directed[i].rec, directed[i].check_typed,
                                    directed[i].typed_status);
    wait_drained();

    // Random phases across timeout settings, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_timeout(16'd0);
        1: write_timeout(16'hFFFF);
        2: write_timeout(16'd2);
        3: write_timeout(16'h8000);
        default: write_timeout(TIMEOUT_RESET);
      endcase
      idle_pct = (phase == 2) ? 0 : 20;
      for (int n = 0; n < 240; n++) begin
        send_beat(random_rec(), 1'b0, 3'd0);
        if (phase == 3 && n == 100) begin
          // Hold the sender until every result is back.
          hold_sender = 1'b1;
          in_ch.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end

    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
